@@ rtl/stdp_trace_synapse_step_assert.svh @@
`ifndef STDP_TRACE_SYNAPSE_STEP_ASSERT_SVH
`define STDP_TRACE_SYNAPSE_STEP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define STDP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("stdp: same-cycle check failed");

// next-cycle implication, disabled during reset
`define STDP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("stdp: next-cycle check failed");

`endif

@@ rtl/stdp_pkg.sv @@
`default_nettype none

package stdp_pkg;

	localparam int TRACE_W  = 17;
	localparam int WEIGHT_W = 18;
	localparam int COND_W   = 28;
	localparam int POT_W    = 19;
	localparam int CUR_W    = 32;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;

	localparam logic [CFG_IDX_W-1:0] CFG_PRE_DECAY   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POST_DECAY  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRE_BUMP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_POST_BUMP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPRESS     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_POTENTIATE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_W_FLOOR     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_W_CEILING   = 3'd7;

	// shared multiplier: unsigned A, signed B, signed product
	localparam int MUL_A_W = 28;
	localparam int MUL_B_W = 26;
	localparam int MUL_P_W = MUL_A_W + 1 + MUL_B_W;

	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 80;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PRE0, S_PRE1, S_PRE2, S_PRE3, S_PRE4,
		S_POST0, S_POST1, S_POST2, S_POST3,
		S_DEC0, S_DEC1, S_DEC2, S_DEC3,
		S_CUR0, S_CUR1
	} stdp_state_t;

	typedef struct packed {
		logic               en;
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} stdp_mul_req_t;

endpackage

`default_nettype wire

@@ rtl/stdp_mul.sv @@
`default_nettype none

module stdp_mul #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                clk,
	input  stdp_pkg::stdp_mul_req_t             req,
	output logic signed [stdp_pkg::MUL_P_W-1:0] q
);
	import stdp_pkg::*;

	logic signed [MUL_P_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= $signed({1'b0, req.a}) * $signed(req.b);
		end
	end

	// floor of product / 2^FRAC_BITS
	assign q = prod_q >>> FRAC_BITS;

endmodule

`default_nettype wire

@@ rtl/stdp_trace_synapse_step.sv @@
// Pair-based STDP synapse with exponential pre/post traces, one update per step.
// Input stream s_axis: one time step per transfer (spike flags, potential, drive).
// Output stream m_axis: one result per step (current, weight, conductance).
// Config port: cfg_we/cfg_index/cfg_data; the user must see that it is written
// only while the block is idle, as the block itself does not enforce this.
// All multiplies run through one registered multiplier under a state sequencer,
// at most one multiply issued per cycle, its product consumed the next cycle. A
// step runs the pre states on a pre spike, the post states on a post spike, or
// the decay states on neither, then the current states that register the result.
// s_axis_tready is high only while the sequencer is idle. A finished result
// sits in an output register, so the next step is accepted while it waits;
// if m_axis_tready stays low, the next result is held back in the final
// sequencer state until the register frees.
// arst_n clears the sequencer and output valid, loads register defaults,
// sets both traces and the conductance to zero and the weight to 1.0.
`default_nettype none

`include "stdp_trace_synapse_step_assert.svh"

module stdp_trace_synapse_step #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [stdp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [stdp_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// pre_spike, post_spike, post_potential, drive_gain, zero pad
	input  logic [stdp_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// syn_current, weight_now, conductance_now, zero pad
	output logic [stdp_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
	import stdp_pkg::*;

	localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;
	localparam logic [15:0] DECAY_RST = 16'((95 * ONE_Q) / 100);
	localparam logic [15:0] BUMP_RST  = 16'((4 * ONE_Q) / 100);
	localparam logic [16:0] GAIN_RST  = 17'(ONE_Q);
	localparam logic [WEIGHT_W-1:0] W_CEIL_RST = WEIGHT_W'(2 * ONE_Q);
	localparam logic [WEIGHT_W-1:0] W_RST      = WEIGHT_W'(ONE_Q);
	localparam logic [MUL_B_W-1:0]  GAMMA_Q    = MUL_B_W'((ONE_Q * 4) / 10);
	localparam logic [TRACE_W-1:0]  TRACE_MAX  = '1;
	localparam logic [COND_W-1:0]   COND_MAX   = '1;
	localparam int PAD_W = OUT_DATA_W - CUR_W - WEIGHT_W - COND_W;

	logic [15:0]          pre_decay_q, post_decay_q, pre_bump_q, post_bump_q;
	logic [16:0]          depress_q, potentiate_q;
	logic [WEIGHT_W-1:0]  w_floor_q, w_ceil_q;

	logic [TRACE_W-1:0]   pre_tr_q, post_tr_q;
	logic [WEIGHT_W-1:0]  weight_q;
	logic [COND_W-1:0]    cond_q, acc_q;

	logic                 post_q;
	logic signed [POT_W-1:0] pot_q;
	logic [COND_W-1:0]    drive_q;

	stdp_state_t          state_q, state_d;
	logic                 out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	stdp_mul_req_t             mreq;
	logic signed [MUL_P_W-1:0] mq;
	logic [MUL_P_W-1:0]        qu;

	logic                      in_xfer, out_load;
	logic [MUL_P_W-1:0]        trace_sum;
	logic [TRACE_W-1:0]        trace_sat;
	logic signed [MUL_P_W:0]   w_base, w_mag, w_sum, w_floor_x, w_lo;
	logic [WEIGHT_W-1:0]       w_new;
	logic [MUL_P_W-1:0]        cond_sum;
	logic [COND_W-1:0]         cond_new;
	logic signed [MUL_B_W-1:0] neg_pot;
	logic                      cur_fits;
	logic [CUR_W-1:0]          cur;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_load      = (state_q == S_CUR1) && (!out_valid_q || m_axis_tready);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	stdp_mul #(
		.FRAC_BITS(FRAC_BITS)
	) u_mul (
		.clk (clk),
		.req (mreq),
		.q   (mq)
	);

	assign qu = unsigned'(mq);
	assign neg_pot = -MUL_B_W'(pot_q);

	always_comb begin
		mreq = '0;
		case (state_q)
			S_PRE0, S_DEC0: begin
				mreq = '{en: 1'b1, a: MUL_A_W'(pre_tr_q), b: MUL_B_W'(pre_decay_q)};
			end
			S_PRE1: begin
				mreq = '{en: 1'b1, a: MUL_A_W'(post_tr_q), b: MUL_B_W'(depress_q)};
			end
			S_PRE2, S_POST2, S_DEC2: begin
				mreq = '{en: 1'b1, a: cond_q, b: GAMMA_Q};
			end
			S_PRE3: begin
				mreq = '{en: 1'b1, a: drive_q, b: MUL_B_W'(weight_q)};
			end
			S_POST0, S_DEC1: begin
				mreq = '{en: 1'b1, a: MUL_A_W'(post_tr_q), b: MUL_B_W'(post_decay_q)};
			end
			S_POST1: begin
				mreq = '{en: 1'b1, a: MUL_A_W'(pre_tr_q), b: MUL_B_W'(potentiate_q)};
			end
			S_CUR0: begin
				mreq = '{en: 1'b1, a: cond_q, b: neg_pot};
			end
			default: begin
				mreq = '0;
			end
		endcase
	end

	// trace: decayed value plus bump, saturated
	always_comb begin
		trace_sum = qu + MUL_P_W'((state_q == S_PRE1) ? pre_bump_q : post_bump_q);
		trace_sat = (trace_sum > MUL_P_W'(TRACE_MAX)) ? TRACE_MAX : trace_sum[TRACE_W-1:0];
	end

	// weight: raise to floor, then lower to ceiling
	always_comb begin
		w_base    = $signed((MUL_P_W+1)'(weight_q));
		w_mag     = $signed({1'b0, qu});
		w_floor_x = $signed((MUL_P_W+1)'(w_floor_q));
		w_sum     = (state_q == S_PRE2) ? (w_base - w_mag) : (w_base + w_mag);
		w_lo      = (w_sum < w_floor_x) ? w_floor_x : w_sum;
		w_new     = (w_lo > $signed((MUL_P_W+1)'(w_ceil_q))) ? w_ceil_q
		                                                     : w_lo[WEIGHT_W-1:0];
	end

	always_comb begin
		cond_sum = qu + ((state_q == S_PRE4) ? MUL_P_W'(acc_q) : '0);
		cond_new = (cond_sum > MUL_P_W'(COND_MAX)) ? COND_MAX : cond_sum[COND_W-1:0];
	end

	always_comb begin
		cur_fits = (mq[MUL_P_W-1:CUR_W-1] == {(MUL_P_W-CUR_W+1){mq[MUL_P_W-1]}});
		if (cur_fits) begin
			cur = mq[CUR_W-1:0];
		end else if (mq[MUL_P_W-1]) begin
			cur = {1'b1, {(CUR_W-1){1'b0}}};
		end else begin
			cur = {1'b0, {(CUR_W-1){1'b1}}};
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					if (s_axis_tdata[0]) begin
						state_d = S_PRE0;
					end else if (s_axis_tdata[1]) begin
						state_d = S_POST0;
					end else begin
						state_d = S_DEC0;
					end
				end
			end
			S_PRE0:  state_d = S_PRE1;
			S_PRE1:  state_d = S_PRE2;
			S_PRE2:  state_d = S_PRE3;
			S_PRE3:  state_d = S_PRE4;
			S_PRE4:  state_d = post_q ? S_POST0 : S_CUR0;
			S_POST0: state_d = S_POST1;
			S_POST1: state_d = S_POST2;
			S_POST2: state_d = S_POST3;
			S_POST3: state_d = S_CUR0;
			S_DEC0:  state_d = S_DEC1;
			S_DEC1:  state_d = S_DEC2;
			S_DEC2:  state_d = S_DEC3;
			S_DEC3:  state_d = S_CUR0;
			S_CUR0:  state_d = S_CUR1;
			S_CUR1: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_decay_q  <= DECAY_RST;
			post_decay_q <= DECAY_RST;
			pre_bump_q   <= BUMP_RST;
			post_bump_q  <= BUMP_RST;
			depress_q    <= GAIN_RST;
			potentiate_q <= GAIN_RST;
			w_floor_q    <= '0;
			w_ceil_q     <= W_CEIL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PRE_DECAY:  pre_decay_q  <= cfg_data[15:0];
				CFG_POST_DECAY: post_decay_q <= cfg_data[15:0];
				CFG_PRE_BUMP:   pre_bump_q   <= cfg_data[15:0];
				CFG_POST_BUMP:  post_bump_q  <= cfg_data[15:0];
				CFG_DEPRESS:    depress_q    <= cfg_data[16:0];
				CFG_POTENTIATE: potentiate_q <= cfg_data[16:0];
				CFG_W_FLOOR:    w_floor_q    <= cfg_data[WEIGHT_W-1:0];
				CFG_W_CEILING:  w_ceil_q     <= cfg_data[WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_tr_q  <= '0;
			post_tr_q <= '0;
			weight_q  <= W_RST;
			cond_q    <= '0;
		end else begin
			case (state_q)
				S_PRE1:  pre_tr_q  <= trace_sat;
				S_POST1: post_tr_q <= trace_sat;
				S_DEC1:  pre_tr_q  <= qu[TRACE_W-1:0];
				S_DEC2:  post_tr_q <= qu[TRACE_W-1:0];
				S_PRE2, S_POST2: weight_q <= w_new;
				S_PRE4, S_POST3, S_DEC3: cond_q <= cond_new;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			post_q  <= s_axis_tdata[1];
			pot_q   <= $signed(s_axis_tdata[2 +: POT_W]);
			drive_q <= s_axis_tdata[2 + POT_W +: COND_W];
		end
		if (state_q == S_PRE3) begin
			acc_q <= qu[COND_W-1:0];
		end
		if (out_load) begin
			out_data_q <= {{PAD_W{1'b0}}, cond_q, weight_q, cur};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	`STDP_ASSERT_NXT(a_busy_after_xfer, clk, arst_n, in_xfer, state_q != S_IDLE)
	`STDP_ASSERT_NXT(a_load_sets_valid, clk, arst_n, out_load, out_valid_q && state_q == S_IDLE)
	`STDP_ASSERT_NXT(a_hold_when_full, clk, arst_n, state_q == S_CUR1 && !out_load, state_q == S_CUR1 && out_valid_q)
	`STDP_ASSERT_IMP(a_post_entry, clk, arst_n, state_q == S_POST0, $past(state_q) == S_PRE4 || $past(state_q) == S_IDLE)

endmodule

`default_nettype wire

@@ dv/tb_stdp_trace_synapse_step.sv @@
`timescale 1ns / 100ps

module tb_stdp_trace_synapse_step;
	import stdp_pkg::*;

	localparam int FRAC = 16;
	localparam int DRIVE_W = 28;
	localparam int IN_USED_W = 2 + POT_W + DRIVE_W;
	localparam longint ONE_Q = longint'(1) << FRAC;
	localparam longint CHARGE_KEEP = (ONE_Q * 4) / 10;
	localparam longint TRACE_TOP = (longint'(1) << TRACE_W) - 1;
	localparam longint COND_TOP = (longint'(1) << COND_W) - 1;
	localparam longint CUR_HI = (longint'(1) << (CUR_W - 1)) - 1;
	localparam longint CUR_LO = -(longint'(1) << (CUR_W - 1));
	localparam int unsigned DECAY_MAX = 65535;
	localparam int unsigned GAIN_MAX = 131071;
	localparam int unsigned W_TOP = 131072;
	localparam logic signed [POT_W-1:0] POT_MAX = {1'b0, {(POT_W-1){1'b1}}};
	localparam logic signed [POT_W-1:0] POT_MIN = {1'b1, {(POT_W-1){1'b0}}};
	localparam logic [DRIVE_W-1:0] DRIVE_MAX = '1;
	localparam longint CYCLE_LIMIT = 1000000;

	typedef struct {
		logic signed [CUR_W-1:0] current;
		logic [WEIGHT_W-1:0]     weight;
		logic [COND_W-1:0]       cond;
	} step_result_t;

	typedef struct {
		int unsigned pre_decay;
		int unsigned post_decay;
		int unsigned pre_bump;
		int unsigned post_bump;
		int unsigned depress;
		int unsigned potentiate;
		int unsigned w_floor;
		int unsigned w_ceiling;
	} syn_cfg_t;

	class synapse_scoreboard;
		longint pre_decay, post_decay, pre_bump, post_bump;
		longint depress, potentiate, w_floor, w_ceiling;
		longint pre_trace, post_trace, weight, cond;
		step_result_t expected[$];
		int steps, results, mismatches;

		function new();
			pre_decay = (95 * ONE_Q) / 100;
			post_decay = (95 * ONE_Q) / 100;
			pre_bump = (4 * ONE_Q) / 100;
			post_bump = (4 * ONE_Q) / 100;
			depress = ONE_Q;
			potentiate = ONE_Q;
			w_floor = 0;
			w_ceiling = 2 * ONE_Q;
			pre_trace = 0;
			post_trace = 0;
			weight = ONE_Q;
			cond = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
			case (idx)
				CFG_PRE_DECAY:  pre_decay = v & 32'hFFFF;
				CFG_POST_DECAY: post_decay = v & 32'hFFFF;
				CFG_PRE_BUMP:   pre_bump = v & 32'hFFFF;
				CFG_POST_BUMP:  post_bump = v & 32'hFFFF;
				CFG_DEPRESS:    depress = v & 32'h1FFFF;
				CFG_POTENTIATE: potentiate = v & 32'h1FFFF;
				CFG_W_FLOOR:    w_floor = v & 32'h3FFFF;
				CFG_W_CEILING:  w_ceiling = v & 32'h3FFFF;
				default: ;
			endcase
		endfunction

		function longint qmul(longint a, longint b);
			return (a * b) >>> FRAC;
		endfunction

		function longint bumped(longint dec, longint tr, longint inc);
			longint v;
			v = qmul(dec, tr) + inc;
			return (v > TRACE_TOP) ? TRACE_TOP : v;
		endfunction

		function longint clamped(longint w);
			if (w < w_floor) w = w_floor;
			if (w > w_ceiling) w = w_ceiling;
			return w & 64'h3FFFF;
		endfunction

		function void note_step(logic [IN_DATA_W-1:0] d);
			bit pre, post;
			longint pot, drive, prod, cur;
			step_result_t r;
			pre = d[0];
			post = d[1];
			pot = $signed(d[POT_W+1:2]);
			drive = d[IN_USED_W-1:POT_W+2];
			if (pre) begin
				pre_trace = bumped(pre_decay, pre_trace, pre_bump);
				weight = clamped(weight - qmul(depress, post_trace));
				cond = qmul(CHARGE_KEEP, cond) + qmul(drive, weight);
				if (cond > COND_TOP) cond = COND_TOP;
			end
			if (post) begin
				post_trace = bumped(post_decay, post_trace, post_bump);
				weight = clamped(weight + qmul(potentiate, pre_trace));
				cond = qmul(CHARGE_KEEP, cond);
			end
			if (!pre && !post) begin
				pre_trace = qmul(pre_decay, pre_trace);
				post_trace = qmul(post_decay, post_trace);
				cond = qmul(CHARGE_KEEP, cond);
			end
			// reversal at zero; floor rounding
			prod = -(cond * pot);
			cur = prod >>> FRAC;
			if (cur > CUR_HI) cur = CUR_HI;
			if (cur < CUR_LO) cur = CUR_LO;
			r.current = cur[CUR_W-1:0];
			r.weight = weight[WEIGHT_W-1:0];
			r.cond = cond[COND_W-1:0];
			expected.push_back(r);
			steps++;
		endfunction

		task report(string what, longint got, longint want);
			mismatches++;
			if (mismatches <= 40)
				$display("%0t mismatch %s on result %0d: got %0d, want %0d",
					$time, what, results, got, want);
		endtask

		task check_result(logic [OUT_DATA_W-1:0] d);
			step_result_t want;
			logic signed [CUR_W-1:0] cur;
			logic [WEIGHT_W-1:0] w;
			logic [COND_W-1:0] g;
			results++;
			cur = d[CUR_W-1:0];
			w = d[CUR_W+WEIGHT_W-1:CUR_W];
			g = d[CUR_W+WEIGHT_W+COND_W-1:CUR_W+WEIGHT_W];
			if (expected.size() == 0) begin
				report("unexpected result", cur, 0);
			end else begin
				want = expected.pop_front();
				if (cur !== want.current) report("syn_current", cur, want.current);
				if (w !== want.weight) report("weight_now", w, want.weight);
				if (g !== want.cond) report("conductance_now", g, want.cond);
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// pre_spike, post_spike, post_potential, drive_gain, zero pad
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// syn_current, weight_now, conductance_now, zero pad
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	synapse_scoreboard sb = new();
	bit quiet = 1'b1;
	int unsigned stall_left = 0;
	longint cycle_count = 0;
	int settings_used = 1;

	always #5 clk = ~clk;

	stdp_trace_synapse_step i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	function automatic int unsigned pause_len();
		if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n && s_axis_tvalid && s_axis_tready) sb.note_step(s_axis_tdata);
		if (arst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
	end

	always @(posedge clk) begin
		if (stall_left != 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 99) < 30) begin
			m_axis_tready <= 1'b0;
			stall_left <= pause_len() - 1;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles", cycle_count);
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic push_step(bit pre, bit post, logic signed [POT_W-1:0] pot,
			logic [DRIVE_W-1:0] drv);
		int unsigned gap;
		s_axis_tdata <= {{(IN_DATA_W-IN_USED_W){1'b0}}, drv, pot, post, pre};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		gap = (quiet || $urandom_range(0, 1)) ? 0 : pause_len();
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic push_random();
		logic [1:0] kind;
		logic signed [POT_W-1:0] pot;
		logic [DRIVE_W-1:0] drv;
		int unsigned r;
		kind = 2'($urandom_range(0, 3));
		r = $urandom_range(0, 9);
		if (r == 0) pot = POT_MIN;
		else if (r == 1) pot = POT_MAX;
		else pot = POT_W'($urandom);
		r = $urandom_range(0, 9);
		if (r < 4) drv = DRIVE_W'($urandom);
		else if (r < 8) drv = DRIVE_W'($urandom_range(0, 1 << 20));
		else if (r == 8) drv = DRIVE_W'($urandom_range(0, 4095));
		else drv = $urandom_range(0, 1) ? DRIVE_MAX : '0;
		push_step(kind[0], kind[1], pot, drv);
	endtask

	// pass a clock edge first so a transfer taken at this edge is already noted
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.expected.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v[CFG_DATA_W-1:0];
		sb.set_reg(idx, v);
		@(posedge clk);
	endtask

	task automatic load_config(syn_cfg_t c);
		write_reg(CFG_PRE_DECAY, c.pre_decay);
		write_reg(CFG_POST_DECAY, c.post_decay);
		write_reg(CFG_PRE_BUMP, c.pre_bump);
		write_reg(CFG_POST_BUMP, c.post_bump);
		write_reg(CFG_DEPRESS, c.depress);
		write_reg(CFG_POTENTIATE, c.potentiate);
		write_reg(CFG_W_FLOOR, c.w_floor);
		write_reg(CFG_W_CEILING, c.w_ceiling);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	function automatic int unsigned pick_reg(int unsigned top);
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 2) return 0;
		if (r < 4) return top;
		return $urandom_range(0, top);
	endfunction

	function automatic syn_cfg_t random_cfg();
		syn_cfg_t c;
		c.pre_decay = pick_reg(DECAY_MAX);
		c.post_decay = pick_reg(DECAY_MAX);
		c.pre_bump = pick_reg(DECAY_MAX);
		c.post_bump = pick_reg(DECAY_MAX);
		c.depress = pick_reg(GAIN_MAX);
		c.potentiate = pick_reg(GAIN_MAX);
		c.w_floor = $urandom_range(0, W_TOP / 2);
		c.w_ceiling = $urandom_range(c.w_floor, W_TOP);
		return c;
	endfunction

	task automatic run_phase(syn_cfg_t c, int n, bit calm);
		wait_drained();
		load_config(c);
		quiet = calm;
		for (int i = 0; i < n; i++) begin
			if (i == n / 2) wait_drained();
			push_random();
		end
		wait_drained();
	endtask

	initial begin
		syn_cfg_t c;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults, directed corners
		push_step(1'b0, 1'b0, '0, '0);
		push_step(1'b1, 1'b0, POT_MAX, DRIVE_MAX);
		push_step(1'b1, 1'b0, POT_MIN, DRIVE_MAX);
		push_step(1'b0, 1'b1, POT_W'(-1), '0);
		push_step(1'b1, 1'b1, POT_MIN, DRIVE_MAX);
		push_step(1'b0, 1'b0, POT_MAX, '0);
		push_step(1'b1, 1'b0, '0, '0);
		push_step(1'b0, 1'b1, POT_W'(1), DRIVE_W'(1));
		push_step(1'b1, 1'b1, POT_W'(-1), DRIVE_W'(12345));
		for (int k = 0; k < 6; k++)
			push_step(k[0] == 0, k[0] == 1, POT_W'(POT_MIN + k * 40000),
				DRIVE_W'(1) << (k * 4));
		for (int k = 0; k < 6; k++)
			push_step(1'b0, 1'b0, POT_MIN, '0);
		quiet = 1'b0;
		for (int i = 0; i < 180; i++) push_random();
		wait_drained();

		c = '{DECAY_MAX, DECAY_MAX, DECAY_MAX, DECAY_MAX, GAIN_MAX, GAIN_MAX, 0, W_TOP};
		run_phase(c, 200, 1'b0);
		c = '{0, 0, 0, 0, 0, 0, 0, 0};
		run_phase(c, 140, 1'b0);
		// floor above ceiling: ceiling wins
		c = '{40000, 50000, 30000, 20000, 90000, 70000, W_TOP, 4096};
		run_phase(c, 140, 1'b0);
		run_phase(random_cfg(), 165, 1'b0);
		run_phase(random_cfg(), 165, 1'b1);
		run_phase(random_cfg(), 165, 1'b0);
		c = '{62259, 62259, 2621, 2621, 65536, 65536, 0, W_TOP};
		run_phase(c, 165, 1'b0);

		repeat (30) @(posedge clk);
		if (sb.expected.size() != 0)
			sb.report("results never delivered", sb.expected.size(), 0);
		$display("checked %0d synapse steps against %0d results under %0d register settings",
			sb.steps, sb.results, settings_used);
		$display("spike combinations, potential and drive extremes, trace and weight limits hit");
		if (sb.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
